FILE: rtl/core/ultrasonic_echo_ranger_assert.svh
// Assertion macros shared by the ranger RTL.
// Clocked implication checks; no other dependencies.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define UER_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define UER_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/uer_pkg.sv
// Shared types and constants of the ultrasonic echo ranger.
// No dependencies; imported by every module of the block.
package uer_pkg;

    // Measurement phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_SETUP   = 3'd1;
    localparam logic [2:0] PH_TRIGGER = 3'd2;
    localparam logic [2:0] PH_GAP     = 3'd3;
    localparam logic [2:0] PH_WAIT    = 3'd4;
    localparam logic [2:0] PH_MEASURE = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_TIMEOUT     = 2'd1;
    localparam logic [1:0] ST_NO_OBSTACLE = 2'd2;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_SETUP       = 3'd0;
    localparam logic [2:0] REG_TRIGGER     = 3'd1;
    localparam logic [2:0] REG_GAP         = 3'd2;
    localparam logic [2:0] REG_RISE_TMO    = 3'd3;
    localparam logic [2:0] REG_MAX_ECHO    = 3'd4;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    // Register reset values
    localparam logic [7:0]  RST_SETUP    = 8'd20;
    localparam logic [7:0]  RST_TRIGGER  = 8'd30;
    localparam logic [7:0]  RST_GAP      = 8'd40;
    localparam logic [19:0] RST_RISE_TMO = 20'd600000;
    localparam logic [15:0] RST_MAX_ECHO = 16'd60000;

    // Microseconds per centimetre of round trip
    localparam int CM_DIVISOR = 58;

    typedef struct packed {
        logic [7:0]  setup_ticks;
        logic [7:0]  trigger_ticks;
        logic [7:0]  gap_ticks;
        logic [19:0] rise_timeout_ticks;
        logic [15:0] max_echo_ticks;
    } cfg_t;

    typedef struct packed {
        logic        trig_level;
        logic        trig_drive;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [14:0] pulse_us;
        logic [9:0]  distance_cm;
    } res_t;

endpackage

FILE: rtl/core/uer_cm_div.sv
// Divide the echo pulse width in microseconds by 58 to get centimetres.
// Uses CM_DIVISOR from uer_pkg; reciprocal multiply, exact for all inputs.
module uer_cm_div import uer_pkg::*; #(
    parameter int PW = 15
) (
    input  logic [PW-1:0] pulse,
    output logic [PW-6:0] quot
);
    // Shift of PW plus ceil(log2(58)) makes the rounded-up reciprocal exact
    localparam int SH    = PW + 6;
    localparam int MUL   = ((1 << SH) + CM_DIVISOR - 1) / CM_DIVISOR;
    localparam int PRODW = 2 * PW + 1;
    localparam logic [PW:0] MUL_V = MUL[PW:0];

    logic [PRODW-1:0] prod;

    // Multiply by the reciprocal and keep the integer part
    assign prod = PRODW'(pulse) * PRODW'(MUL_V);
    assign quot = prod[SH +: (PW - 5)];

endmodule

FILE: rtl/core/uer_apb_regs.sv
// APB configuration registers of the ultrasonic echo ranger.
// Depends on uer_pkg for register indexes, reset values and cfg_t.
module uer_apb_regs import uer_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);
    cfg_t cfg_reg;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign cfg     = cfg_reg;

    // Write the addressed register in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.setup_ticks        <= RST_SETUP;
            cfg_reg.trigger_ticks      <= RST_TRIGGER;
            cfg_reg.gap_ticks          <= RST_GAP;
            cfg_reg.rise_timeout_ticks <= RST_RISE_TMO;
            cfg_reg.max_echo_ticks     <= RST_MAX_ECHO;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SETUP:    cfg_reg.setup_ticks        <= pwdata[7:0];
                REG_TRIGGER:  cfg_reg.trigger_ticks      <= pwdata[7:0];
                REG_GAP:      cfg_reg.gap_ticks          <= pwdata[7:0];
                REG_RISE_TMO: cfg_reg.rise_timeout_ticks <= pwdata[19:0];
                REG_MAX_ECHO: cfg_reg.max_echo_ticks     <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register, zero beyond the map
    always_comb begin
        case (reg_idx)
            REG_SETUP:    prdata = APB_DATA_W'(cfg_reg.setup_ticks);
            REG_TRIGGER:  prdata = APB_DATA_W'(cfg_reg.trigger_ticks);
            REG_GAP:      prdata = APB_DATA_W'(cfg_reg.gap_ticks);
            REG_RISE_TMO: prdata = APB_DATA_W'(cfg_reg.rise_timeout_ticks);
            REG_MAX_ECHO: prdata = APB_DATA_W'(cfg_reg.max_echo_ticks);
            default:      prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/uer_sequencer.sv
// Measurement sequencer: phase and tick counter, one update per tick.
// Depends on uer_pkg and uer_cm_div; produces the result of each tick.
`include "ultrasonic_echo_ranger_assert.svh"
module uer_sequencer import uer_pkg::*; #(
    parameter int RISE_COUNT_WIDTH = 20,
    parameter int ECHO_COUNT_WIDTH = 16
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic step,
    input  logic start_req,
    input  logic echo_level,
    input  cfg_t cfg,
    output res_t res
);
    localparam int RCW  = RISE_COUNT_WIDTH;
    localparam int ECW  = ECHO_COUNT_WIDTH;
    localparam int PW   = ECW - 1;
    localparam int CW0  = (RCW > ECW) ? RCW : ECW;
    localparam int CW   = (CW0 > 9) ? CW0 : 9;
    localparam int CMPW = (CW > 20) ? CW : 20;
    localparam logic [CMPW-1:0] ONE_C       = 1;
    localparam logic [CMPW-1:0] RISE_MASK_C = (ONE_C << RCW) - ONE_C;
    localparam logic [CMPW-1:0] ECHO_MASK_C = (ONE_C << ECW) - ONE_C;

    logic [2:0]      phase_reg, phase_next;
    logic [CW-1:0]   tick_count_reg, tick_count_next;

    logic            start_go;
    logic [2:0]      eff_phase;
    logic [CW-1:0]   eff_cnt, cnt_inc, sat_cnt;
    logic [CMPW-1:0] cnt_cmp, inc_cmp, sat_cmp, rise_to, max_echo;
    logic [7:0]      trig_len;
    logic            done;
    logic [1:0]      status;
    logic            pulse_ok;
    logic [PW-1:0]   pulse;
    logic [PW-6:0]   cm_quot;
    logic [31:0]     pulse_ext, dist_ext;

    // Centimetre conversion of the finished pulse
    uer_cm_div #(.PW(PW)) u_cm_div (
        .pulse (pulse),
        .quot  (cm_quot)
    );

    assign pulse     = tick_count_reg[ECW-1:1];
    assign pulse_ext = 32'(pulse);
    assign dist_ext  = 32'(cm_quot);

    // A start while idle enters setup (or trigger) on this same tick
    assign start_go  = (phase_reg == PH_IDLE) && start_req;
    assign eff_phase = start_go ? ((cfg.setup_ticks == 8'd0) ? PH_TRIGGER : PH_SETUP)
                                : phase_reg;
    assign eff_cnt   = start_go ? '0 : tick_count_reg;
    assign cnt_inc   = eff_cnt + CW'(1);
    assign cnt_cmp   = CMPW'(eff_cnt);
    assign inc_cmp   = CMPW'(cnt_inc);
    assign rise_to   = CMPW'(cfg.rise_timeout_ticks);
    assign max_echo  = CMPW'(cfg.max_echo_ticks);
    assign trig_len  = (cfg.trigger_ticks == 8'd0) ? 8'd1 : cfg.trigger_ticks;

    // Saturating count for the wait and measure phases
    always_comb begin
        if (eff_phase == PH_WAIT) begin
            sat_cnt = (cnt_cmp < RISE_MASK_C) ? cnt_inc : eff_cnt;
        end else begin
            sat_cnt = (cnt_cmp < ECHO_MASK_C) ? cnt_inc : eff_cnt;
        end
    end
    assign sat_cmp = CMPW'(sat_cnt);

    // Advance the phase and judge the end of a measurement
    always_comb begin
        phase_next      = eff_phase;
        tick_count_next = cnt_inc;
        done            = 1'b0;
        status          = ST_OK;
        pulse_ok        = 1'b0;
        case (eff_phase)
            PH_IDLE: begin
                tick_count_next = '0;
            end
            PH_SETUP: begin
                if (inc_cmp >= CMPW'(cfg.setup_ticks)) begin
                    phase_next      = PH_TRIGGER;
                    tick_count_next = '0;
                end
            end
            PH_TRIGGER: begin
                if (inc_cmp >= CMPW'(trig_len)) begin
                    phase_next      = (cfg.gap_ticks == 8'd0) ? PH_WAIT : PH_GAP;
                    tick_count_next = '0;
                end
            end
            PH_GAP: begin
                if (inc_cmp >= CMPW'(cfg.gap_ticks)) begin
                    phase_next      = PH_WAIT;
                    tick_count_next = '0;
                end
            end
            PH_WAIT: begin
                if (echo_level) begin
                    phase_next      = PH_MEASURE;
                    tick_count_next = CW'(1);
                    if (max_echo == '0) begin
                        done   = 1'b1;
                        status = ST_NO_OBSTACLE;
                    end
                end else begin
                    tick_count_next = sat_cnt;
                    if ((sat_cmp >= rise_to) || (sat_cmp >= RISE_MASK_C)) begin
                        done   = 1'b1;
                        status = ST_TIMEOUT;
                    end
                end
            end
            PH_MEASURE: begin
                if (echo_level) begin
                    tick_count_next = sat_cnt;
                    if ((sat_cmp > max_echo) || (sat_cmp >= ECHO_MASK_C)) begin
                        done   = 1'b1;
                        status = ST_NO_OBSTACLE;
                    end
                end else begin
                    tick_count_next = eff_cnt;
                    done            = 1'b1;
                    if (cnt_cmp > max_echo) begin
                        status = ST_NO_OBSTACLE;
                    end else begin
                        pulse_ok = 1'b1;
                    end
                end
            end
            default: begin
                phase_next      = PH_IDLE;
                tick_count_next = '0;
            end
        endcase
        if (done) begin
            phase_next      = PH_IDLE;
            tick_count_next = '0;
        end
    end

    // Assemble the tick's result from the phase in force
    always_comb begin
        res.trig_level  = (eff_phase == PH_TRIGGER);
        res.trig_drive  = (eff_phase == PH_SETUP) || (eff_phase == PH_TRIGGER) ||
                          (eff_phase == PH_GAP);
        res.busy_res    = (eff_phase != PH_IDLE);
        res.done_res    = done;
        res.status      = status;
        res.pulse_us    = pulse_ok ? pulse_ext[14:0] : 15'd0;
        res.distance_cm = pulse_ok ? dist_ext[9:0] : 10'd0;
    end

    // Update state once per accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            tick_count_reg <= '0;
        end else if (step) begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
        end
    end

    `UER_ASSERT_IMP(a_idle_cnt_zero, aclk, aresetn, phase_reg == PH_IDLE, tick_count_reg == '0, "idle phase with nonzero tick count")
    `UER_ASSERT_IMP(a_measure_cnt, aclk, aresetn, phase_reg == PH_MEASURE, tick_count_reg != '0, "measure phase with zero echo count")
    `UER_ASSERT_NXT(a_done_to_idle, aclk, aresetn, step && done, phase_reg == PH_IDLE, "finished measurement did not return to idle")

endmodule

FILE: rtl/core/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: handshake, result register, APB.
// Depends on uer_pkg, uer_apb_regs and uer_sequencer.
//
//  channel   ports                     payload
//  s_        s_valid / s_ready         start_req, echo_level (one tick)
//  m_        m_valid / m_ready         trig/drive/busy/done, status, pulse, cm
//  apb       psel / penable / pready   five config registers at 4 * index
//
// One tick is accepted per cycle unless m_ready stalls; its result is in the
// output register in the cycle after acceptance. The rate is set by the phase
// and tick counter update in the sequencer.
// aresetn (synchronous) returns to idle and restores register defaults.
// A stalled m_ready holds the result and lowers s_ready; ticks do not advance.
`include "ultrasonic_echo_ranger_assert.svh"
module ultrasonic_echo_ranger import uer_pkg::*; #(
    parameter int RISE_COUNT_WIDTH = 20,
    parameter int ECHO_COUNT_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_start_req,
    input  logic                  s_echo_level,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_trig_level,
    output logic                  m_trig_drive,
    output logic                  m_busy_res,
    output logic                  m_done_res,
    output logic [1:0]            m_status,
    output logic [14:0]           m_pulse_us,
    output logic [9:0]            m_distance_cm,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    cfg_t cfg;
    res_t res;
    res_t res_reg;
    logic m_valid_reg;
    logic step;

    uer_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    uer_sequencer #(
        .RISE_COUNT_WIDTH (RISE_COUNT_WIDTH),
        .ECHO_COUNT_WIDTH (ECHO_COUNT_WIDTH)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .start_req  (s_start_req),
        .echo_level (s_echo_level),
        .cfg        (cfg),
        .res        (res)
    );

    // Take a transaction whenever the result register is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign step    = s_valid && s_ready;

    // Capture the result, drop valid once it is taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= res;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_trig_level  = res_reg.trig_level;
    assign m_trig_drive  = res_reg.trig_drive;
    assign m_busy_res    = res_reg.busy_res;
    assign m_done_res    = res_reg.done_res;
    assign m_status      = res_reg.status;
    assign m_pulse_us    = res_reg.pulse_us;
    assign m_distance_cm = res_reg.distance_cm;

    `UER_ASSERT_IMP(a_done_busy, aclk, aresetn, m_valid_reg && m_done_res, m_busy_res, "done result outside a measurement")
    `UER_ASSERT_IMP(a_status_done, aclk, aresetn, m_valid_reg && (m_status != ST_OK), m_done_res, "status reported without done")
    `UER_ASSERT_IMP(a_level_drive, aclk, aresetn, m_valid_reg && m_trig_level, m_trig_drive && m_busy_res, "trigger high on a released pin")

endmodule

FILE: test/testbench.sv
// Self-checking testbench for ultrasonic_echo_ranger: directed table, then random
// measurement sequences checked against an in-bench predictor of the sequencer.
// Depends on uer_pkg and the ultrasonic_echo_ranger RTL only.
`timescale 1ns / 100ps

module testbench;
    import uer_pkg::*;

    localparam int          STALL_LIMIT = 4000;
    localparam logic [19:0] RISE_SAT    = 20'hFFFFF;
    localparam logic [19:0] ECHO_SAT    = 20'h0FFFF;
    localparam res_t        QUIET       = '0;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_DST, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic start;
        logic echo;
        logic typed;
        res_t want;
    } dir_row_t;

    // Short measurements with setup, trigger and gap of one tick, timeout 3, echo limit 4
    localparam dir_row_t DIR_TAB [22] = '{
        '{1'b0, 1'b0, 1'b1, QUIET},                                       // idle tick
        '{1'b1, 1'b0, 1'b0, QUIET},                                       // start: setup
        '{1'b1, 1'b1, 1'b0, QUIET},                                       // start while busy
        '{1'b0, 1'b1, 1'b0, QUIET},                                       // gap
        '{1'b0, 1'b1, 1'b0, QUIET},                                       // echo rises
        '{1'b0, 1'b1, 1'b0, QUIET},
        '{1'b1, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, ST_OK, 15'd1, 10'd0}},
        '{1'b1, 1'b0, 1'b0, QUIET},                                       // next start
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b0, QUIET},
        '{1'b0, 1'b0, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, ST_TIMEOUT, 15'd0, 10'd0}},
        '{1'b1, 1'b1, 1'b0, QUIET},                                       // echo ignored in setup
        '{1'b0, 1'b1, 1'b0, QUIET},
        '{1'b0, 1'b1, 1'b0, QUIET},
        '{1'b0, 1'b1, 1'b0, QUIET},
        '{1'b0, 1'b1, 1'b0, QUIET},
        '{1'b0, 1'b1, 1'b0, QUIET},
        '{1'b0, 1'b1, 1'b0, QUIET},                                       // count equals limit
        '{1'b0, 1'b1, 1'b1, '{1'b0, 1'b0, 1'b1, 1'b1, ST_NO_OBSTACLE, 15'd0, 10'd0}},
        '{1'b0, 1'b1, 1'b1, QUIET}
    };

    logic                  aclk         = 1'b0;
    logic                  aresetn      = 1'b0;
    logic                  s_valid      = 1'b0;
    logic                  s_ready;
    logic                  s_start_req  = 1'b0;
    logic                  s_echo_level = 1'b0;
    logic                  m_valid;
    logic                  m_ready      = 1'b0;
    logic                  m_trig_level;
    logic                  m_trig_drive;
    logic                  m_busy_res;
    logic                  m_done_res;
    logic [1:0]            m_status;
    logic [14:0]           m_pulse_us;
    logic [9:0]            m_distance_cm;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [APB_ADDR_W-1:0] paddr        = '0;
    logic [APB_DATA_W-1:0] pwdata       = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // Predictor state and its copy of the registers
    cfg_t        ranger_cfg;
    logic [2:0]  seq_ph;
    logic [19:0] seq_cnt;

    res_t        readings_q [$];
    res_t        seen_res;
    res_t        wanted_res;
    int unsigned bad_count   = 0;
    int unsigned sent_count  = 0;
    int unsigned quiet_cycles = 0;
    int          src_pct     = 0;
    int          dst_pct     = 0;

    ultrasonic_echo_ranger u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_req   (s_start_req),
        .s_echo_level  (s_echo_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_trig_level  (m_trig_level),
        .m_trig_drive  (m_trig_drive),
        .m_busy_res    (m_busy_res),
        .m_done_res    (m_done_res),
        .m_status      (m_status),
        .m_pulse_us    (m_pulse_us),
        .m_distance_cm (m_distance_cm),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Advance the sequencer by one tick and return the reading it produces
    function automatic res_t ranger_tick(input logic start, input logic echo);
        res_t        r;
        logic        fin;
        logic [19:0] trig_len;
        logic [14:0] us;
        r   = '0;
        fin = 1'b0;
        if (seq_ph == PH_IDLE && start) begin
            seq_cnt = '0;
            seq_ph  = (ranger_cfg.setup_ticks == 8'd0) ? PH_TRIGGER : PH_SETUP;
        end
        r.busy_res   = (seq_ph != PH_IDLE);
        r.trig_drive = (seq_ph == PH_SETUP || seq_ph == PH_TRIGGER || seq_ph == PH_GAP);
        r.trig_level = (seq_ph == PH_TRIGGER);
        case (seq_ph)
            PH_SETUP: begin
                seq_cnt = seq_cnt + 1'b1;
                if (seq_cnt >= ranger_cfg.setup_ticks) begin
                    seq_ph  = PH_TRIGGER;
                    seq_cnt = '0;
                end
            end
            PH_TRIGGER: begin
                trig_len = (ranger_cfg.trigger_ticks == 8'd0) ? 20'd1 :
                           {12'd0, ranger_cfg.trigger_ticks};
                seq_cnt  = seq_cnt + 1'b1;
                if (seq_cnt >= trig_len) begin
                    seq_cnt = '0;
                    seq_ph  = (ranger_cfg.gap_ticks == 8'd0) ? PH_WAIT : PH_GAP;
                end
            end
            PH_GAP: begin
                seq_cnt = seq_cnt + 1'b1;
                if (seq_cnt >= ranger_cfg.gap_ticks) begin
                    seq_ph  = PH_WAIT;
                    seq_cnt = '0;
                end
            end
            PH_WAIT: begin
                if (echo) begin
                    seq_ph  = PH_MEASURE;
                    seq_cnt = 20'd1;
                    if (seq_cnt > ranger_cfg.max_echo_ticks) begin
                        fin      = 1'b1;
                        r.status = ST_NO_OBSTACLE;
                    end
                end else begin
                    if (seq_cnt < RISE_SAT)
                        seq_cnt = seq_cnt + 1'b1;
                    if (seq_cnt >= ranger_cfg.rise_timeout_ticks || seq_cnt >= RISE_SAT) begin
                        fin      = 1'b1;
                        r.status = ST_TIMEOUT;
                    end
                end
            end
            PH_MEASURE: begin
                if (echo) begin
                    if (seq_cnt < ECHO_SAT)
                        seq_cnt = seq_cnt + 1'b1;
                    if (seq_cnt > ranger_cfg.max_echo_ticks || seq_cnt >= ECHO_SAT) begin
                        fin      = 1'b1;
                        r.status = ST_NO_OBSTACLE;
                    end
                end else begin
                    fin = 1'b1;
                    if (seq_cnt > ranger_cfg.max_echo_ticks) begin
                        r.status = ST_NO_OBSTACLE;
                    end else begin
                        us            = seq_cnt[15:1];
                        r.status      = ST_OK;
                        r.pulse_us    = us;
                        r.distance_cm = 10'(us / CM_DIVISOR);
                    end
                end
            end
            default: begin
                seq_ph  = PH_IDLE;
                seq_cnt = '0;
            end
        endcase
        if (fin) begin
            seq_ph  = PH_IDLE;
            seq_cnt = '0;
        end
        r.done_res = fin;
        return r;
    endfunction

    function automatic logic [31:0] reg_field(input logic [2:0] idx);
        case (idx)
            REG_SETUP:    return {24'd0, ranger_cfg.setup_ticks};
            REG_TRIGGER:  return {24'd0, ranger_cfg.trigger_ticks};
            REG_GAP:      return {24'd0, ranger_cfg.gap_ticks};
            REG_RISE_TMO: return {12'd0, ranger_cfg.rise_timeout_ticks};
            REG_MAX_ECHO: return {16'd0, ranger_cfg.max_echo_ticks};
            default:      return 32'd0;
        endcase
    endfunction

    function automatic string fmt_res(input res_t r);
        return $sformatf("lvl=%0d drv=%0d busy=%0d done=%0d st=%0d us=%0d cm=%0d",
                         r.trig_level, r.trig_drive, r.busy_res, r.done_res,
                         r.status, r.pulse_us, r.distance_cm);
    endfunction

    task automatic log_mismatch(input string msg);
        bad_count++;
        if (bad_count <= 10)
            $display("MISMATCH: %s", msg);
    endtask

    task automatic set_mode(input idle_mode_t m);
        case (m)
            IDLE_SRC:  begin src_pct = 46; dst_pct = 0;  end
            IDLE_DST:  begin src_pct = 0;  dst_pct = 46; end
            IDLE_BOTH: begin src_pct = 30; dst_pct = 30; end
            default:   begin src_pct = 0;  dst_pct = 0;  end
        endcase
    endtask

    // Read a register and compare it with the predictor's copy
    task automatic check_reg(input logic [2:0] idx);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        if (got !== reg_field(idx))
            log_mismatch($sformatf("register %0d read 0x%08h, expected 0x%08h",
                                   idx, got, reg_field(idx)));
    endtask

    // Write a register, mirror it into the predictor, read it back
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        case (idx)
            REG_SETUP:    ranger_cfg.setup_ticks        = val[7:0];
            REG_TRIGGER:  ranger_cfg.trigger_ticks      = val[7:0];
            REG_GAP:      ranger_cfg.gap_ticks          = val[7:0];
            REG_RISE_TMO: ranger_cfg.rise_timeout_ticks = val[19:0];
            REG_MAX_ECHO: ranger_cfg.max_echo_ticks     = val[15:0];
            default: ;
        endcase
        check_reg(idx);
    endtask

    // Send one tick; hold valid and payload until the transaction is accepted
    task automatic send_tick(input logic start, input logic echo,
                             input logic typed = 1'b0, input res_t want = '0);
        res_t pred;
        while (src_pct != 0 && $urandom_range(99) < src_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_start_req  <= start;
        s_echo_level <= echo;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        pred = ranger_tick(start, echo);
        readings_q.push_back(typed ? want : pred);
        sent_count++;
    endtask

    // Stop sending until every outstanding reading has come back
    task automatic drain();
        s_valid <= 1'b0;
        while (readings_q.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    // Bring the sequencer back to idle, then drain
    task automatic quiesce();
        while (seq_ph != PH_IDLE)
            send_tick(1'b0, seq_ph == PH_WAIT);
        drain();
    endtask

    // Program all registers with junk in the bits above each field
    task automatic apply_cfg(input logic [7:0] su, input logic [7:0] tr, input logic [7:0] gp,
                             input logic [19:0] rt, input logic [15:0] me);
        logic [31:0] junk;
        quiesce();
        junk = $urandom();
        reg_write(REG_SETUP,    {junk[31:8], su});
        reg_write(REG_TRIGGER,  {junk[23:0], tr});
        reg_write(REG_GAP,      {junk[15:0], junk[31:24], gp});
        reg_write(REG_RISE_TMO, {junk[31:20], rt});
        reg_write(REG_MAX_ECHO, {junk[15:0], me});
    endtask

    // One well-formed measurement: start, drive phases, rise after a delay, echo width
    task automatic run_measure(input int unsigned rise_delay, input int unsigned width);
        int unsigned i;
        send_tick(1'b1, 1'($urandom_range(1)));
        while (seq_ph == PH_SETUP || seq_ph == PH_TRIGGER || seq_ph == PH_GAP)
            send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
        for (i = 0; i < rise_delay && seq_ph == PH_WAIT; i++)
            send_tick(1'($urandom_range(1)), 1'b0);
        for (i = 0; i < width && (seq_ph == PH_WAIT || seq_ph == PH_MEASURE); i++)
            send_tick(1'($urandom_range(1)), 1'b1);
        if (seq_ph == PH_MEASURE)
            send_tick(1'($urandom_range(1)), 1'b0);
    endtask

    // Mostly measurements with random timing, some noise, idle ticks and drains
    task automatic run_random(input int unsigned n);
        int unsigned target;
        int unsigned pick;
        int unsigned rise_cap;
        int unsigned width_cap;
        int unsigned i;
        target = sent_count + n;
        while (sent_count < target) begin
            pick      = $urandom_range(99);
            rise_cap  = (ranger_cfg.rise_timeout_ticks > 60) ? 60 :
                        ranger_cfg.rise_timeout_ticks + 2;
            width_cap = (ranger_cfg.max_echo_ticks > 60) ? 60 :
                        ranger_cfg.max_echo_ticks + 3;
            if (pick < 75) begin
                run_measure($urandom_range(rise_cap), $urandom_range(width_cap));
            end else if (pick < 88) begin
                for (i = $urandom_range(8, 1); i > 0; i--)
                    send_tick(1'($urandom_range(1)), 1'($urandom_range(1)));
            end else if (pick < 97) begin
                for (i = $urandom_range(4, 1); i > 0; i--)
                    send_tick(1'b0, 1'($urandom_range(1)));
            end else begin
                drain();
            end
        end
    endtask

    // Receiver: stall at the current rate
    always @(posedge aclk)
        m_ready <= ($urandom_range(99) >= dst_pct);

    // Compare each accepted reading with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_res = '{m_trig_level, m_trig_drive, m_busy_res, m_done_res,
                         m_status, m_pulse_us, m_distance_cm};
            if (readings_q.size() == 0) begin
                log_mismatch({"unexpected reading ", fmt_res(seen_res)});
            end else begin
                wanted_res = readings_q.pop_front();
                if (seen_res !== wanted_res)
                    log_mismatch({"expected ", fmt_res(wanted_res),
                                  " got ", fmt_res(seen_res)});
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial begin : main_seq
        int k;
        ranger_cfg = '{RST_SETUP, RST_TRIGGER, RST_GAP, RST_RISE_TMO, RST_MAX_ECHO};
        seq_ph     = PH_IDLE;
        seq_cnt    = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Registers come up at their defaults
        check_reg(REG_SETUP);
        check_reg(REG_TRIGGER);
        check_reg(REG_GAP);
        check_reg(REG_RISE_TMO);
        check_reg(REG_MAX_ECHO);

        // Directed table
        set_mode(IDLE_NONE);
        apply_cfg(8'd1, 8'd1, 8'd1, 20'd3, 16'd4);
        foreach (DIR_TAB[i])
            send_tick(DIR_TAB[i].start, DIR_TAB[i].echo, DIR_TAB[i].typed, DIR_TAB[i].want);
        set_mode(IDLE_SRC);
        run_random(150);

        // All zero: skipped setup and gap, one-tick trigger, instant timeout and limit
        set_mode(IDLE_DST);
        apply_cfg(8'd0, 8'd0, 8'd0, 20'd0, 16'd0);
        run_random(250);

        // Reset values
        set_mode(IDLE_BOTH);
        apply_cfg(RST_SETUP, RST_TRIGGER, RST_GAP, RST_RISE_TMO, RST_MAX_ECHO);
        run_random(300);

        // Largest settings: longest drive phases, then a rise well before the timeout
        set_mode(IDLE_NONE);
        apply_cfg(8'hFF, 8'hFF, 8'hFF, 20'hFFFFF, 16'hFFFF);
        run_measure(3, 40);

        // Random small settings, rotating through the idle modes
        for (k = 0; k < 6; k++) begin
            set_mode(idle_mode_t'(k % 4));
            apply_cfg(8'($urandom_range(6)), 8'($urandom_range(6)), 8'($urandom_range(6)),
                      20'($urandom_range(20)), 16'($urandom_range(30)));
            run_random(100);
        end

        quiesce();
        repeat (8) @(posedge aclk);
        if (bad_count == 0 && readings_q.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
